// ===== rtl/ifam_pkg.sv =====
// ----------------------------------------------------------------------------
// Infusion flow alarm monitor package
// Alarm codes, opcodes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package ifam_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned FLOW_W   = 24;
    localparam int unsigned TARGET_W = 16;
    localparam int unsigned TMO_W    = 20;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(0);
    localparam logic [TMO_W-1:0]    STOP_TMO_RST = TMO_W'(15000);
    localparam logic [TMO_W-1:0]    HOLD_RST     = TMO_W'(10000);
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = PERIOD_W'(500);

    typedef enum logic [1:0] {
        ALM_IDLE    = 2'd0,
        ALM_NO_DROP = 2'd1,
        ALM_RATE    = 2'd2
    } t_alarm;

    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_MUTE  = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RATE = 2'd0,
        CFG_STOP_TMO    = 2'd1,
        CFG_FLOW_HOLD   = 2'd2,
        CFG_BEEP_PERIOD = 2'd3
    } t_cfg_idx;

    // 10 * |flow - target*256| > target*256
    function automatic logic out_of_band(
        input logic [FLOW_W-1:0]   flow,
        input logic [TARGET_W-1:0] target
    );
        logic [FLOW_W-1:0] t;
        logic [FLOW_W-1:0] d;
        logic [FLOW_W+3:0] d10;
        t = {target, 8'h00};
        d = (flow > t) ? (flow - t) : (t - flow);
        d10 = {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
        return d10 > {4'b0000, t};
    endfunction

endpackage

// ===== rtl/infusion_flow_alarm_monitor.sv =====
// ----------------------------------------------------------------------------
// Infusion flow alarm monitor
// Drop timeout and flow band alarms with beep pacing and mute.
// Each request passes the input register and then the result register; a
// result held by the receiver stalls the input register.
// Throughput: one request per cycle while the result is taken; set by the state update.
// Reset: synchronous, active low; clears alarm state, deviation timer, beep
// time and mute flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module infusion_flow_alarm_monitor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [ifam_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [ifam_pkg::TIME_W-1:0]         i_drop_time_ms,
    input  logic [ifam_pkg::FLOW_W-1:0]         i_flow_rate,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_alarm_code,
    output logic                                o_beep,
    output logic                                o_alarm_started,
    output logic                                o_alarm_cleared,
    output logic                                o_silence,
    output logic                                o_is_muted,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ifam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ifam_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic [ifam_pkg::TARGET_W-1:0] r_target;
    logic [ifam_pkg::TMO_W-1:0]    r_stop_tmo;
    logic [ifam_pkg::TMO_W-1:0]    r_hold;
    logic [ifam_pkg::PERIOD_W-1:0] r_period;

    // state
    ifam_pkg::t_alarm              r_alarm, n_alarm;
    logic [ifam_pkg::TIME_W-1:0]   r_dev_start, n_dev_start;
    logic [ifam_pkg::TIME_W-1:0]   r_last_beep, n_last_beep;
    logic                          r_muted, n_muted;

    // input stage
    logic                          r_in_valid;
    logic                          r_opcode;
    logic [ifam_pkg::TIME_W-1:0]   r_now;
    logic [ifam_pkg::TIME_W-1:0]   r_drop;
    logic [ifam_pkg::FLOW_W-1:0]   r_flow;

    // result stage
    logic                          r_out_valid;
    logic [1:0]                    r_alarm_code;
    logic                          r_beep, r_started, r_cleared, r_silence, r_is_muted;

    logic                          n_beep, n_started, n_cleared, n_silence;
    logic [ifam_pkg::TIME_W-1:0]   since_drop, since_beep, since_dev;
    logic                          oob;
    logic                          advance;
    logic                          in_take;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign since_drop = r_now - r_drop;
    assign since_beep = r_now - r_last_beep;
    assign since_dev  = r_now - r_dev_start;
    assign oob        = ifam_pkg::out_of_band(r_flow, r_target);

    always_comb begin
        n_alarm     = r_alarm;
        n_dev_start = r_dev_start;
        n_last_beep = r_last_beep;
        n_muted     = r_muted;
        n_beep      = 1'b0;
        n_started   = 1'b0;
        n_cleared   = 1'b0;
        n_silence   = 1'b0;
        if (r_opcode == ifam_pkg::OP_MUTE) begin
            n_muted   = 1'b1;
            n_silence = 1'b1;
        end else if (r_alarm != ifam_pkg::ALM_IDLE) begin
            if (!r_muted && (since_beep >= {16'h0000, r_period})) begin
                n_last_beep = r_now;
                n_beep      = 1'b1;
            end
            if (r_alarm == ifam_pkg::ALM_NO_DROP) begin
                if (since_drop < {12'h000, r_stop_tmo}) begin
                    n_alarm   = ifam_pkg::ALM_IDLE;
                    n_cleared = 1'b1;
                end
            end else if (r_alarm == ifam_pkg::ALM_RATE) begin
                if (!oob) begin
                    n_alarm     = ifam_pkg::ALM_IDLE;
                    n_cleared   = 1'b1;
                    n_dev_start = '0;
                end
            end
        end else if (since_drop >= {12'h000, r_stop_tmo}) begin
            n_alarm   = ifam_pkg::ALM_NO_DROP;
            n_muted   = 1'b0;
            n_started = 1'b1;
        end else if (r_target != '0) begin
            if (oob) begin
                if (r_dev_start == '0) begin
                    n_dev_start = r_now;
                end else if (since_dev >= {12'h000, r_hold}) begin
                    n_alarm   = ifam_pkg::ALM_RATE;
                    n_muted   = 1'b0;
                    n_started = 1'b1;
                end
            end else begin
                n_dev_start = '0;
            end
        end else begin
            n_dev_start = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= ifam_pkg::TARGET_RST;
            r_stop_tmo  <= ifam_pkg::STOP_TMO_RST;
            r_hold      <= ifam_pkg::HOLD_RST;
            r_period    <= ifam_pkg::PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (ifam_pkg::t_cfg_idx'(i_cfg_index))
                ifam_pkg::CFG_TARGET_RATE: r_target   <= i_cfg_data[ifam_pkg::TARGET_W-1:0];
                ifam_pkg::CFG_STOP_TMO:    r_stop_tmo <= i_cfg_data[ifam_pkg::TMO_W-1:0];
                ifam_pkg::CFG_FLOW_HOLD:   r_hold     <= i_cfg_data[ifam_pkg::TMO_W-1:0];
                ifam_pkg::CFG_BEEP_PERIOD: r_period   <= i_cfg_data[ifam_pkg::PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm     <= ifam_pkg::ALM_IDLE;
            r_dev_start <= '0;
            r_last_beep <= '0;
            r_muted     <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_alarm     <= n_alarm;
                r_dev_start <= n_dev_start;
                r_last_beep <= n_last_beep;
                r_muted     <= n_muted;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_opcode <= i_opcode;
            r_now    <= i_now_ms;
            r_drop   <= i_drop_time_ms;
            r_flow   <= i_flow_rate;
        end
        if (advance) begin
            r_alarm_code <= n_alarm;
            r_beep       <= n_beep;
            r_started    <= n_started;
            r_cleared    <= n_cleared;
            r_silence    <= n_silence;
            r_is_muted   <= n_muted;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_alarm_code    = r_alarm_code;
    assign o_beep          = r_beep;
    assign o_alarm_started = r_started;
    assign o_alarm_cleared = r_cleared;
    assign o_silence       = r_silence;
    assign o_is_muted      = r_is_muted;

    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_alarm_started && o_alarm_cleared))
        else $error("alarm raised and cleared in one request");

    a_started_unmuted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_started) |->
            (o_alarm_code != ifam_pkg::ALM_IDLE) && !o_is_muted)
        else $error("raised alarm without code or still muted");

    a_silence_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_silence) |->
            o_is_muted && !o_beep && !o_alarm_started && !o_alarm_cleared)
        else $error("mute result carries other events");

    a_cleared_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_alarm_cleared) |-> (o_alarm_code == ifam_pkg::ALM_IDLE))
        else $error("cleared alarm still reported");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(advance) |-> $stable(r_alarm) && $stable(r_muted))
        else $error("alarm state changed without a request");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Infusion flow alarm monitor testbench
// Drives check and mute requests through the valid/ready input channel and
// compares every result with a cycle-free prediction of the alarm state
// machine. Directed tests cover reset values, the flow band edges, mute,
// 32-bit time wrap and zero timeouts. Random traffic then runs sticky drop
// and flow trends under changing register settings and four idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import ifam_pkg::*;

    localparam int QUIET_LIMIT  = 10000;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTING_SPAN = 70;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    typedef struct packed {
        logic [1:0] code;
        logic       beep;
        logic       started;
        logic       cleared;
        logic       silence;
        logic       muted;
    } t_alarm_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_opcode;
    logic [TIME_W-1:0]     i_now_ms;
    logic [TIME_W-1:0]     i_drop_time_ms;
    logic [FLOW_W-1:0]     i_flow_rate;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_alarm_code;
    logic                  o_beep;
    logic                  o_alarm_started;
    logic                  o_alarm_cleared;
    logic                  o_silence;
    logic                  o_is_muted;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predicted block state and registers
    t_alarm                alarm_now    = ALM_IDLE;
    logic [TIME_W-1:0]     dev_start_ms = '0;
    logic [TIME_W-1:0]     beep_time_ms = '0;
    logic                  muted        = 1'b0;
    logic [TARGET_W-1:0]   cfg_target   = TARGET_RST;
    logic [TMO_W-1:0]      cfg_stop_tmo = STOP_TMO_RST;
    logic [TMO_W-1:0]      cfg_hold     = HOLD_RST;
    logic [PERIOD_W-1:0]   cfg_period   = PERIOD_RST;

    t_alarm_result         alarm_due_q[$];

    // stimulus side copy of the settings and trend state
    logic [TARGET_W-1:0]   stim_target = TARGET_RST;
    logic [TMO_W-1:0]      stim_stop   = STOP_TMO_RST;
    logic [TMO_W-1:0]      stim_hold   = HOLD_RST;
    logic [TIME_W-1:0]     gen_now;
    logic [TIME_W-1:0]     gen_drop;
    logic                  drops_stalled = 1'b0;
    logic                  flow_off      = 1'b0;

    t_idle_mode            idle_mode = IDLE_NONE;
    int                    quiet_cycles = 0;
    int                    failures = 0;
    int                    requests = 0;
    int                    mutes_sent = 0;
    int                    stops_raised = 0;
    int                    flows_raised = 0;
    int                    clears = 0;
    int                    beeps = 0;
    int                    settings_applied = 0;

    infusion_flow_alarm_monitor u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_now_ms        (i_now_ms),
        .i_drop_time_ms  (i_drop_time_ms),
        .i_flow_rate     (i_flow_rate),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_alarm_code    (o_alarm_code),
        .o_beep          (o_beep),
        .o_alarm_started (o_alarm_started),
        .o_alarm_cleared (o_alarm_cleared),
        .o_silence       (o_silence),
        .o_is_muted      (o_is_muted),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // 10 * |flow - target*256| > target*256, exact
    function automatic logic flow_outside_band(input logic [FLOW_W-1:0] flow);
        logic [27:0] t;
        logic [27:0] f;
        logic [27:0] d;
        t = {4'h0, cfg_target, 8'h00};
        f = {4'h0, flow};
        d = (f > t) ? (f - t) : (t - f);
        return (d * 28'd10) > t;
    endfunction

    function automatic t_alarm_result next_alarm_result(
        input t_opcode           op,
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] drop,
        input logic [FLOW_W-1:0] flow
    );
        t_alarm_result     res;
        logic [TIME_W-1:0] since_drop;
        logic [TIME_W-1:0] since_beep;
        logic [TIME_W-1:0] since_dev;
        res        = '0;
        since_drop = now - drop;
        since_beep = now - beep_time_ms;
        since_dev  = now - dev_start_ms;
        if (op == OP_MUTE) begin
            muted       = 1'b1;
            res.silence = 1'b1;
        end else if (alarm_now != ALM_IDLE) begin
            // beep decision first, then the clear test
            if (!muted && since_beep >= TIME_W'(cfg_period)) begin
                beep_time_ms = now;
                res.beep     = 1'b1;
            end
            if (alarm_now == ALM_NO_DROP) begin
                if (since_drop < TIME_W'(cfg_stop_tmo)) begin
                    alarm_now   = ALM_IDLE;
                    res.cleared = 1'b1;
                end
            end else if (!flow_outside_band(flow)) begin
                alarm_now    = ALM_IDLE;
                res.cleared  = 1'b1;
                dev_start_ms = '0;
            end
        end else if (since_drop >= TIME_W'(cfg_stop_tmo)) begin
            alarm_now   = ALM_NO_DROP;
            muted       = 1'b0;
            res.started = 1'b1;
        end else if (cfg_target != '0 && flow_outside_band(flow)) begin
            // zero start means the deviation timer is idle
            if (dev_start_ms == '0) begin
                dev_start_ms = now;
            end else if (since_dev >= TIME_W'(cfg_hold)) begin
                alarm_now   = ALM_RATE;
                muted       = 1'b0;
                res.started = 1'b1;
            end
        end else begin
            dev_start_ms = '0;
        end
        res.code  = alarm_now;
        res.muted = muted;
        return res;
    endfunction

    always @(posedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: begin
                i_out_ready <= ($urandom_range(99) >= 88);
            end
            IDLE_BOTH: begin
                i_out_ready <= ($urandom_range(99) >= 17);
            end
            default: begin
                i_out_ready <= 1'b1;
            end
        endcase
    end

    always @(posedge i_clk) begin : monitor
        t_alarm_result want;
        t_alarm_result got;
        logic          any_request;
        if (i_rst_n) begin
            any_request = 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                any_request = 1'b1;
                case (i_cfg_index)
                    CFG_TARGET_RATE: cfg_target   = i_cfg_data[TARGET_W-1:0];
                    CFG_STOP_TMO:    cfg_stop_tmo = i_cfg_data[TMO_W-1:0];
                    CFG_FLOW_HOLD:   cfg_hold     = i_cfg_data[TMO_W-1:0];
                    CFG_BEEP_PERIOD: cfg_period   = i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready) begin
                any_request = 1'b1;
                got = {o_alarm_code, o_beep, o_alarm_started, o_alarm_cleared,
                       o_silence, o_is_muted};
                if (alarm_due_q.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("ERROR: unexpected result code=%0d beep=%0b start=%0b clear=%0b silence=%0b muted=%0b",
                                 got.code, got.beep, got.started, got.cleared,
                                 got.silence, got.muted);
                end else begin
                    want = alarm_due_q.pop_front();
                    if (got.code != want.code || got.beep != want.beep ||
                        got.started != want.started || got.cleared != want.cleared ||
                        got.silence != want.silence || got.muted != want.muted) begin
                        failures++;
                        if (failures <= MAX_REPORTS) begin
                            $display("ERROR: expected code=%0d beep=%0b start=%0b clear=%0b silence=%0b muted=%0b",
                                     want.code, want.beep, want.started, want.cleared,
                                     want.silence, want.muted);
                            $display("       actual   code=%0d beep=%0b start=%0b clear=%0b silence=%0b muted=%0b",
                                     got.code, got.beep, got.started, got.cleared,
                                     got.silence, got.muted);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                any_request = 1'b1;
                want = next_alarm_result(t_opcode'(i_opcode), i_now_ms, i_drop_time_ms,
                                         i_flow_rate);
                alarm_due_q.push_back(want);
                requests++;
                if (want.silence)
                    mutes_sent++;
                if (want.started && want.code == ALM_NO_DROP)
                    stops_raised++;
                if (want.started && want.code == ALM_RATE)
                    flows_raised++;
                if (want.cleared)
                    clears++;
                if (want.beep)
                    beeps++;
            end
            quiet_cycles <= any_request ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < QUIET_LIMIT);
        $display("ERROR: no request accepted for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(
        input t_opcode           op,
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] drop,
        input logic [FLOW_W-1:0] flow
    );
        int gap_pct;
        int gap;
        gap_pct = (idle_mode == IDLE_SENDER) ? 88 : (idle_mode == IDLE_BOTH) ? 17 : 0;
        gap     = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_now_ms       <= now;
        i_drop_time_ms <= drop;
        i_flow_rate    <= flow;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_for_results;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (alarm_due_q.size() != 0);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // registers change only with the block drained
    task automatic apply_config(
        input logic [CFG_DATA_W-1:0] target,
        input logic [CFG_DATA_W-1:0] stop,
        input logic [CFG_DATA_W-1:0] hold,
        input logic [CFG_DATA_W-1:0] period
    );
        wait_for_results();
        write_register(CFG_TARGET_RATE, target);
        write_register(CFG_STOP_TMO, stop);
        write_register(CFG_FLOW_HOLD, hold);
        write_register(CFG_BEEP_PERIOD, period);
        i_cfg_valid <= 1'b0;
        stim_target = target[TARGET_W-1:0];
        stim_stop   = stop[TMO_W-1:0];
        stim_hold   = hold[TMO_W-1:0];
        settings_applied++;
    endtask

    task automatic test_reset_defaults;
        send_item(OP_CHECK, 32'd14999, 32'd0, 24'h001234);
        send_item(OP_CHECK, 32'd15000, 32'd0, 24'h000000);
        send_item(OP_CHECK, 32'd15500, 32'd15500, 24'h000000);
    endtask

    task automatic test_flow_band_and_mute;
        // target 100 mL/h: T = 25600, band edge at 2560
        apply_config(20'd100, 20'd1000, 20'd200, 20'd50);
        send_item(OP_CHECK, 32'd0, 32'd0, 24'd25600);
        send_item(OP_CHECK, 32'd0, 32'd0, 24'd0);
        send_item(OP_CHECK, 32'd10, 32'd0, 24'd28161);
        send_item(OP_CHECK, 32'd300, 32'd250, 24'd0);
        send_item(OP_CHECK, 32'd320, 32'd300, 24'd0);
        send_item(OP_MUTE, $urandom, $urandom, 24'($urandom));
        send_item(OP_CHECK, 32'd400, 32'd390, 24'd0);
        send_item(OP_CHECK, 32'd410, 32'd400, 24'd23040);
        send_item(OP_CHECK, 32'd500, 32'd500, 24'd0);
        send_item(OP_CHECK, 32'd800, 32'd800, 24'd0);
        // flow alarm held while target drops to zero
        apply_config(20'd0, 20'd1000, 20'd200, 20'd50);
        send_item(OP_CHECK, 32'd810, 32'd810, 24'd5);
        send_item(OP_CHECK, 32'd820, 32'd820, 24'd0);
    endtask

    task automatic test_stop_and_wrap;
        apply_config({4'hF, 16'hFFFF}, 20'hFFFFF, 20'hFFFFF, {4'hA, 16'hFFFF});
        send_item(OP_CHECK, 32'hFFFF_FFF0, 32'hFFFF_FFF0, 24'hFFFFFF);
        send_item(OP_CHECK, 32'h0000_0005, 32'hFFFF_FFF0, 24'h000000);
        send_item(OP_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 24'hFFFFFF);
        send_item(OP_CHECK, 32'h0001_0000, 32'h0001_0000, 24'h000000);
    endtask

    task automatic test_zero_settings;
        apply_config(20'd1, 20'd0, 20'd0, 20'd0);
        send_item(OP_CHECK, 32'd1000, 32'd1000, 24'd256);
        send_item(OP_CHECK, 32'd1001, 32'd1001, 24'd256);
        apply_config(20'd1, 20'd1000, 20'd0, 20'd0);
        send_item(OP_CHECK, 32'd1002, 32'd1002, 24'd256);
        send_item(OP_CHECK, 32'd1003, 32'd1003, 24'd0);
        send_item(OP_CHECK, 32'd1003, 32'd1003, 24'd0);
        send_item(OP_CHECK, 32'd1003, 32'd1003, 24'd230);
        send_item(OP_CHECK, 32'd1004, 32'd1004, 24'd231);
    endtask

    task automatic test_random_traffic(input t_idle_mode mode, input int n_items);
        logic [3:0]        nib;
        logic [TIME_W-1:0] drop_field;
        int                t_fixed;
        int                tenth;
        int                flow_val;
        int                sel;
        wait_for_results();
        idle_mode = mode;
        for (int n = 0; n < n_items; n++) begin
            if (n % SETTING_SPAN == 0) begin
                nib = 4'($urandom_range(15));
                case (settings_applied % 5)
                    0: apply_config({nib, 16'hFFFF}, 20'hFFFFF, 20'hFFFFF, {nib, 16'hFFFF});
                    1: apply_config({nib, 16'($urandom_range(1))}, 20'd1, 20'd1,
                                    {nib, 16'd1});
                    2: apply_config({nib, 16'h0000}, 20'($urandom_range(1, 3000)),
                                    20'($urandom_range(1, 3000)),
                                    {nib, 16'($urandom_range(1, 400))});
                    3: apply_config({nib, 16'($urandom)}, 20'($urandom_range(1, 3000)),
                                    20'($urandom_range(1, 3000)),
                                    {nib, 16'($urandom_range(1, 400))});
                    default: apply_config({nib, 16'($urandom_range(1, 2000))},
                                          20'($urandom_range(1, 20'hFFFFF)),
                                          20'($urandom_range(1, 20'hFFFFF)),
                                          {nib, 16'($urandom_range(1, 16'hFFFF))});
                endcase
            end
            if ($urandom_range(13) == 0) begin
                send_item(OP_MUTE, $urandom, $urandom, 24'($urandom));
            end else begin
                if ($urandom_range(39) == 0)
                    gen_now = $urandom;
                else
                    gen_now = gen_now + $urandom_range(0, (stim_stop + stim_hold) / 3 + 2);
                if ($urandom_range(5) == 0)
                    drops_stalled = !drops_stalled;
                if (!drops_stalled)
                    gen_drop = gen_now - $urandom_range(0, stim_stop / 2);
                sel = $urandom_range(29);
                if (sel == 0)
                    drop_field = $urandom;
                else if (sel == 1)
                    drop_field = gen_now - stim_stop + $urandom_range(1);
                else
                    drop_field = gen_drop;

                t_fixed = stim_target * 256;
                tenth   = t_fixed / 10;
                if ($urandom_range(6) == 0)
                    flow_off = !flow_off;
                sel = $urandom_range(19);
                if (sel == 0)
                    flow_val = $urandom_range(0, 24'hFFFFFF);
                else if (flow_off && sel < 6)
                    flow_val = $urandom_range(1) ? t_fixed + tenth + 1 : t_fixed - tenth - 1;
                else if (flow_off)
                    flow_val = $urandom_range(1) ? 0 :
                               t_fixed + tenth + 1 + $urandom_range(0, t_fixed / 2 + 256);
                else if (sel < 6)
                    flow_val = $urandom_range(1) ? t_fixed + tenth : t_fixed - tenth;
                else
                    flow_val = t_fixed - tenth + $urandom_range(0, 2 * tenth);
                if (flow_val < 0)
                    flow_val = 0;
                else if (flow_val > 24'hFFFFFF)
                    flow_val = 24'hFFFFFF;
                send_item(OP_CHECK, gen_now, drop_field, 24'(flow_val));
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_CHECK;
        i_now_ms       <= '0;
        i_drop_time_ms <= '0;
        i_flow_rate    <= '0;
        i_out_ready    <= 1'b1;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_TARGET_RATE;
        i_cfg_data     <= '0;
        gen_now  = $urandom;
        gen_drop = gen_now;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_flow_band_and_mute();
        test_stop_and_wrap();
        test_zero_settings();
        test_random_traffic(IDLE_NONE, 350);
        test_random_traffic(IDLE_SENDER, 350);
        test_random_traffic(IDLE_RECEIVER, 350);
        test_random_traffic(IDLE_BOTH, 350);

        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d requests (%0d mutes) across %0d register settings and four idle patterns",
                 requests, mutes_sent, settings_applied);
        $display("Alarms raised: %0d STOP, %0d FLOW; %0d cleared, %0d beeps; %0d failures",
                 stops_raised, flows_raised, clears, beeps, failures);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
